### design/mlap_pkg.sv
// shared constants, codes and types for the mesh laplacian delta coordinate block
// no dependencies; used by every module of the block
package mlap_pkg;

    localparam int IDX_W       = 6;
    localparam int IN_COORD_W  = 32;
    localparam int CNT_W       = 6;
    localparam int DELTA_W     = 33;
    localparam int REQ_W       = 2;
    localparam int S_TDATA_W   = 120;
    localparam int M_TDATA_W   = 112;

    localparam int MAX_VERTS_DEF  = 64;
    localparam int COORD_BITS_DEF = 32;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TRI   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd3;

    // command from the main controller to the adjacency store
    typedef struct packed {
        logic             rd_go;
        logic             add_tri;
        logic             clr_go;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
    } adj_cmd_t;

endpackage

### design/mlap_adj.sv
// adjacency bit store: one row per vertex, with clearing sweep and triangle update
// depends on mlap_pkg
module mlap_adj #(
    parameter int MAX_VERTS = mlap_pkg::MAX_VERTS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  mlap_pkg::adj_cmd_t    cmd,
    output logic                  busy,
    output logic [MAX_VERTS-1:0]  row_rdata
);

    localparam int VIDX_W = $clog2(MAX_VERTS);

    localparam logic [1:0] A_IDLE  = 2'd0;
    localparam logic [1:0] A_CLEAR = 2'd1;
    localparam logic [1:0] A_RD    = 2'd2;
    localparam logic [1:0] A_WR    = 2'd3;

    logic [MAX_VERTS-1:0] mem [MAX_VERTS];
    logic [MAX_VERTS-1:0] rdata_reg;

    logic [1:0]           state_reg, state_next;
    logic [VIDX_W-1:0]    ptr_reg, ptr_next;
    logic [1:0]           left_reg, left_next;
    logic [VIDX_W-1:0]    corner_reg [3];
    logic [MAX_VERTS-1:0] mask_reg;

    logic                 wr_en, rd_en;
    logic [VIDX_W-1:0]    wr_addr, rd_addr;
    logic [MAX_VERTS-1:0] wr_data;
    logic [VIDX_W-1:0]    ca, cb, cc;

    assign ca = VIDX_W'(cmd.a);
    assign cb = VIDX_W'(cmd.b);
    assign cc = VIDX_W'(cmd.c);

    always_comb begin
        wr_en   = (state_reg == A_CLEAR) || (state_reg == A_WR);
        wr_addr = (state_reg == A_CLEAR) ? ptr_reg : corner_reg[0];
        wr_data = (state_reg == A_CLEAR) ? '0 : (rdata_reg | mask_reg);
        rd_en   = ((state_reg == A_IDLE) && cmd.rd_go) || (state_reg == A_RD);
        rd_addr = (state_reg == A_RD) ? corner_reg[0] : VIDX_W'(cmd.row);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        left_next  = left_reg;
        unique case (state_reg)
            A_IDLE: begin
                if (cmd.clr_go) begin
                    state_next = A_CLEAR;
                    ptr_next   = '0;
                end else if (cmd.add_tri) begin
                    state_next = A_RD;
                    left_next  = 2'd2;
                end
            end
            A_CLEAR: begin
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == VIDX_W'(MAX_VERTS - 1)) begin
                    state_next = A_IDLE;
                end
            end
            A_RD: begin
                state_next = A_WR;
            end
            A_WR: begin
                left_next = left_reg - 1'b1;
                state_next = (left_reg == 2'd0) ? A_IDLE : A_RD;
            end
            default: begin
                state_next = A_IDLE;
            end
        endcase
    end

    // sweep the whole store after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_CLEAR;
            ptr_reg   <= '0;
            left_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            left_reg  <= left_next;
        end
    end

    // the same mask goes into each of the three corner rows
    always_ff @(posedge aclk) begin
        if ((state_reg == A_IDLE) && cmd.add_tri && !cmd.clr_go) begin
            corner_reg[0] <= ca;
            corner_reg[1] <= cb;
            corner_reg[2] <= cc;
            mask_reg      <= (MAX_VERTS'(1) << ca) | (MAX_VERTS'(1) << cb)
                           | (MAX_VERTS'(1) << cc);
        end else if (state_reg == A_WR) begin
            corner_reg[0] <= corner_reg[1];
            corner_reg[1] <= corner_reg[2];
        end
    end

    assign busy      = (state_reg != A_IDLE);
    assign row_rdata = rdata_reg;

endmodule

### design/mlap_div.sv
// three-lane restoring divider, one quotient bit per cycle, truncating toward zero
// depends on mlap_pkg
module mlap_div #(
    parameter int ACC_W = mlap_pkg::COORD_BITS_DEF + 1 + mlap_pkg::CNT_W
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mlap_pkg::CNT_W-1:0]  divisor,
    input  logic signed [ACC_W-1:0]     num [3],
    output logic                        done,
    output logic signed [ACC_W-1:0]     quo [3]
);

    localparam int STEP_W = $clog2(ACC_W + 1);
    localparam int CW     = mlap_pkg::CNT_W;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CW-1:0]     dvs_reg;
    logic [ACC_W-1:0]  mag_reg [3];
    logic [CW-1:0]     rem_reg [3];
    logic              neg_reg [3];

    logic [CW:0]       trial [3];
    logic              fit   [3];
    logic [CW-1:0]     rem_next [3];
    logic [ACC_W-1:0]  mag_next [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            trial[k]    = {rem_reg[k], mag_reg[k][ACC_W-1]};
            fit[k]      = (trial[k] >= {1'b0, dvs_reg});
            rem_next[k] = fit[k] ? CW'(trial[k] - {1'b0, dvs_reg}) : CW'(trial[k]);
            mag_next[k] = {mag_reg[k][ACC_W-2:0], fit[k]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(ACC_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend register doubles as the quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            dvs_reg <= divisor;
            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= num[k][ACC_W-1];
                mag_reg[k] <= num[k][ACC_W-1] ? ACC_W'(-num[k]) : ACC_W'(num[k]);
                rem_reg[k] <= '0;
            end
        end else if (busy_reg) begin
            for (int k = 0; k < 3; k++) begin
                mag_reg[k] <= mag_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            quo[k] = neg_reg[k] ? -$signed(mag_reg[k]) : $signed(mag_reg[k]);
        end
    end

    assign done = done_reg;

endmodule

### design/mesh_laplacian_delta_coords.sv
// Uniform Laplacian delta coordinates over a small triangle mesh. Loads write a vertex
// position into the position memory. A triangle makes three read-modify-write passes
// over the adjacency rows of its corners. A clear, and also reset, sweeps the adjacency
// store one row a cycle, during which no beat is taken. A query for a valid vertex
// walks its row one column a cycle through the single read port of the position
// memory, then, if it found any neighbour, a bit-serial divider works through the
// accumulator one bit at a time. The result waits in an output register so the next
// beat may enter meanwhile.
// depends on mlap_pkg, mlap_adj, mlap_div
module mesh_laplacian_delta_coords #(
    parameter int MAX_VERTS  = mlap_pkg::MAX_VERTS_DEF,
    parameter int COORD_BITS = mlap_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // vert_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [mlap_pkg::S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [mlap_pkg::REQ_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // neighbour_count, delta_x, delta_y, delta_z, zero pad
    output logic [mlap_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam int VIDX_W = $clog2(MAX_VERTS);
    localparam int CW     = mlap_pkg::CNT_W;
    localparam int DW     = mlap_pkg::DELTA_W;
    localparam int ACC_W  = COORD_BITS + 1 + CW;
    localparam int PW     = 3 * COORD_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROW   = 3'd1;
    localparam logic [2:0] S_WALK  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]                 state_reg, state_next;
    logic                       accept;
    logic                       adj_busy;
    logic [MAX_VERTS-1:0]       adj_row;
    mlap_pkg::adj_cmd_t         cmd;

    logic [mlap_pkg::IDX_W-1:0] f_vi, f_a, f_b, f_c;
    logic [COORD_BITS-1:0]      f_pos [3];
    logic                       vi_ok, tri_ok;

    logic [PW-1:0]              pos_mem [MAX_VERTS];
    logic [PW-1:0]              pos_rdata_reg;
    logic                       pos_wen;
    logic [VIDX_W-1:0]          pos_raddr;

    logic [VIDX_W-1:0]          vi_reg;
    logic [VIDX_W-1:0]          j_reg;
    logic [MAX_VERTS-1:0]       row_reg;
    logic                       hit_reg;
    logic [CW-1:0]              deg_reg;
    logic signed [COORD_BITS-1:0] own_reg [3];
    logic signed [ACC_W-1:0]    acc_reg [3];
    logic signed [COORD_BITS:0] diff [3];
    logic                       zero_reg;

    logic                       div_start, div_done;
    logic signed [ACC_W-1:0]    quo [3];

    logic                       m_tvalid_reg;
    logic [mlap_pkg::M_TDATA_W-1:0] m_tdata_reg;
    logic                       out_load;

    assign f_vi     = s_tdata[5:0];
    assign f_pos[0] = COORD_BITS'($signed(s_tdata[37:6]));
    assign f_pos[1] = COORD_BITS'($signed(s_tdata[69:38]));
    assign f_pos[2] = COORD_BITS'($signed(s_tdata[101:70]));
    assign f_a      = s_tdata[107:102];
    assign f_b      = s_tdata[113:108];
    assign f_c      = s_tdata[119:114];

    assign vi_ok  = int'(f_vi) < MAX_VERTS;
    assign tri_ok = (int'(f_a) < MAX_VERTS) && (int'(f_b) < MAX_VERTS)
                 && (int'(f_c) < MAX_VERTS);

    assign s_tready = (state_reg == S_IDLE) && !adj_busy;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd.rd_go   = accept && (s_tuser == mlap_pkg::REQ_QUERY) && vi_ok;
        cmd.add_tri = accept && (s_tuser == mlap_pkg::REQ_TRI) && tri_ok;
        cmd.clr_go  = accept && (s_tuser == mlap_pkg::REQ_CLEAR);
        cmd.row     = f_vi;
        cmd.a       = f_a;
        cmd.b       = f_b;
        cmd.c       = f_c;
    end

    mlap_adj #(
        .MAX_VERTS (MAX_VERTS)
    ) u_adj (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .busy      (adj_busy),
        .row_rdata (adj_row)
    );

    // position memory, x in the low bits
    assign pos_wen   = accept && (s_tuser == mlap_pkg::REQ_LOAD) && vi_ok;
    assign pos_raddr = (state_reg == S_WALK) ? j_reg : VIDX_W'(f_vi);

    always_ff @(posedge aclk) begin
        if (pos_wen) begin
            pos_mem[VIDX_W'(f_vi)] <= {f_pos[2], f_pos[1], f_pos[0]};
        end
        pos_rdata_reg <= pos_mem[pos_raddr];
    end

    always_comb begin
        state_next = state_reg;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (accept && (s_tuser == mlap_pkg::REQ_QUERY)) begin
                    state_next = vi_ok ? S_ROW : S_OUT;
                end
            end
            S_ROW: begin
                state_next = S_WALK;
            end
            S_WALK: begin
                if (j_reg == VIDX_W'(MAX_VERTS - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_START;
            end
            S_START: begin
                if (deg_reg == '0) begin
                    state_next = S_OUT;
                end else begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            // neighbour flag lines up with the position read it goes with
            hit_reg <= (state_reg == S_WALK) && row_reg[0] && (j_reg != vi_reg);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = (COORD_BITS + 1)'(own_reg[k])
                    - (COORD_BITS + 1)'($signed(pos_rdata_reg[k*COORD_BITS +: COORD_BITS]));
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && (s_tuser == mlap_pkg::REQ_QUERY)) begin
            vi_reg   <= VIDX_W'(f_vi);
            deg_reg  <= '0;
            zero_reg <= 1'b1;
            for (int k = 0; k < 3; k++) begin
                acc_reg[k] <= '0;
            end
        end else begin
            if (state_reg == S_ROW) begin
                row_reg <= adj_row;
                j_reg   <= '0;
                for (int k = 0; k < 3; k++) begin
                    own_reg[k] <= $signed(pos_rdata_reg[k*COORD_BITS +: COORD_BITS]);
                end
            end else if (state_reg == S_WALK) begin
                row_reg <= row_reg >> 1;
                j_reg   <= j_reg + 1'b1;
            end
            if (hit_reg) begin
                deg_reg <= deg_reg + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    acc_reg[k] <= acc_reg[k] + ACC_W'(diff[k]);
                end
            end
            if (div_start) begin
                zero_reg <= 1'b0;
            end
        end
    end

    mlap_div #(
        .ACC_W (ACC_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .divisor (deg_reg),
        .num     (acc_reg),
        .done    (div_done),
        .quo     (quo)
    );

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {7'd0,
                            zero_reg ? DW'(0) : DW'(quo[2]),
                            zero_reg ? DW'(0) : DW'(quo[1]),
                            zero_reg ? DW'(0) : DW'(quo[0]),
                            deg_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

### bench/mlap_checker.sv
// checker for the mesh laplacian delta coordinate block: watches both stream channels,
// predicts each query answer from its own copy of the mesh state and compares field by field
// depends on mlap_pkg
`timescale 1ns / 1ps

module mlap_checker
    import mlap_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // vert_index, pos_x, pos_y, pos_z, corner_a, corner_b, corner_c
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // req_type
    input  logic [REQ_W-1:0]      s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // neighbour_count, delta_x, delta_y, delta_z, zero pad
    input  logic [M_TDATA_W-1:0]  m_tdata,
    output int                    n_waiting,
    output int                    n_fail,
    output int                    n_results
);

    localparam int NV     = MAX_VERTS_DEF;
    localparam int PX_LSB = IDX_W;
    localparam int PY_LSB = PX_LSB + IN_COORD_W;
    localparam int PZ_LSB = PY_LSB + IN_COORD_W;
    localparam int CA_LSB = PZ_LSB + IN_COORD_W;
    localparam int CB_LSB = CA_LSB + IDX_W;
    localparam int CC_LSB = CB_LSB + IDX_W;
    localparam int RES_W  = CNT_W + 3 * DELTA_W;

    // packed from the top down, so the count ends up in the lowest bits as on the bus
    typedef struct packed {
        logic [DELTA_W-1:0] dz;
        logic [DELTA_W-1:0] dy;
        logic [DELTA_W-1:0] dx;
        logic [CNT_W-1:0]   count;
    } delta_res_t;

    logic [NV-1:0]                 adj_row [NV];
    logic signed [IN_COORD_W-1:0]  pos_x [NV];
    logic signed [IN_COORD_W-1:0]  pos_y [NV];
    logic signed [IN_COORD_W-1:0]  pos_z [NV];
    delta_res_t                    delta_q [$];

    function automatic delta_res_t predict_delta(input int vi);
        delta_res_t res;
        longint     sx, sy, sz, deg;
        int         j;
        sx  = 0;
        sy  = 0;
        sz  = 0;
        deg = 0;
        for (j = 0; j < NV; j++) begin
            if (j != vi && adj_row[vi][j]) begin
                deg++;
                sx += longint'(pos_x[vi]) - longint'(pos_x[j]);
                sy += longint'(pos_y[vi]) - longint'(pos_y[j]);
                sz += longint'(pos_z[vi]) - longint'(pos_z[j]);
            end
        end
        // division of signed longints truncates toward zero
        if (deg > 0) begin
            sx = sx / deg;
            sy = sy / deg;
            sz = sz / deg;
        end
        res.count = CNT_W'(deg);
        res.dx    = DELTA_W'(sx);
        res.dy    = DELTA_W'(sy);
        res.dz    = DELTA_W'(sz);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [DELTA_W-1:0] want,
                               input logic [DELTA_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            n_fail++;
        end
    endtask

    always @(posedge aclk) begin : watch
        delta_res_t got, want;
        logic [IDX_W-1:0] idx, ca, cb, cc;
        int k;
        if (!aresetn) begin
            for (k = 0; k < NV; k++) adj_row[k] = '0;
            delta_q.delete();
        end else begin
            // a result beat can never belong to a query taken on the same edge
            if (m_tvalid && m_tready) begin
                got = delta_res_t'(m_tdata[RES_W-1:0]);
                n_results++;
                if (delta_q.size() == 0) begin
                    $error("result beat with no query outstanding");
                    n_fail++;
                end else begin
                    want = delta_q.pop_front();
                    check_field("neighbour_count", DELTA_W'(want.count), DELTA_W'(got.count));
                    check_field("delta_x", want.dx, got.dx);
                    check_field("delta_y", want.dy, got.dy);
                    check_field("delta_z", want.dz, got.dz);
                end
            end
            if (s_tvalid && s_tready) begin
                idx = s_tdata[IDX_W-1:0];
                ca  = s_tdata[CA_LSB +: IDX_W];
                cb  = s_tdata[CB_LSB +: IDX_W];
                cc  = s_tdata[CC_LSB +: IDX_W];
                case (s_tuser)
                    REQ_LOAD: begin
                        pos_x[idx] = s_tdata[PX_LSB +: IN_COORD_W];
                        pos_y[idx] = s_tdata[PY_LSB +: IN_COORD_W];
                        pos_z[idx] = s_tdata[PZ_LSB +: IN_COORD_W];
                    end
                    REQ_TRI: begin
                        adj_row[ca][ca] = 1'b1;
                        adj_row[cb][cb] = 1'b1;
                        adj_row[cc][cc] = 1'b1;
                        adj_row[ca][cb] = 1'b1;
                        adj_row[cb][ca] = 1'b1;
                        adj_row[ca][cc] = 1'b1;
                        adj_row[cc][ca] = 1'b1;
                        adj_row[cb][cc] = 1'b1;
                        adj_row[cc][cb] = 1'b1;
                    end
                    REQ_QUERY: begin
                        delta_q.insert(delta_q.size(), predict_delta(int'(idx)));
                    end
                    REQ_CLEAR: begin
                        for (k = 0; k < NV; k++) adj_row[k] = '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
        n_waiting <= delta_q.size();
    end

endmodule

### bench/tb_top.sv
// top of the testbench: clock, reset, stream stimulus with random idling and the verdict
// depends on mlap_pkg, mesh_laplacian_delta_coords and mlap_checker
`timescale 1ns / 1ps

module tb_top;
    import mlap_pkg::*;

    localparam int          NV        = MAX_VERTS_DEF;
    localparam int          ITEMS     = 850;
    localparam int          LONG_HOLD = 1500;
    localparam int          SETTLE    = 200;
    localparam int unsigned LIMIT     = 800000;
    localparam logic [IN_COORD_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [IN_COORD_W-1:0] Q_MIN = 32'h8000_0000;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [REQ_W-1:0]      s_tuser  = REQ_LOAD;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    int          n_waiting, n_fail, n_results;
    int unsigned cycle_cnt = 0;
    int          n_sent    = 0;
    int          n_kind [4];
    bit          loaded [NV];
    bit          tx_idle_on  = 1'b1;
    bit          rx_idle_on  = 1'b1;
    bit          rx_hold_req = 1'b0;

    always #10 aclk = ~aclk;

    mesh_laplacian_delta_coords dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mlap_checker chk (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .n_waiting (n_waiting),
        .n_fail    (n_fail),
        .n_results (n_results)
    );

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stall per beat, with the odd long hold-off
    initial begin : receiver
        int gap;
        forever begin
            if (rx_hold_req) begin
                gap = LONG_HOLD;
                rx_hold_req = 1'b0;
            end else begin
                if ($urandom_range(0, 19) == 0) rx_idle_on = !rx_idle_on;
                gap = rx_idle_on ? $urandom_range(0, 3) : 0;
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && aresetn));
        end
    end

    function automatic logic [IN_COORD_W-1:0] rand_coord();
        case ($urandom_range(0, 7))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return IN_COORD_W'($signed($urandom_range(0, 2097152)) - 1048576);
            default: return $urandom;
        endcase
    endfunction

    // any vertex that has a position; the directed part guarantees there is one
    function automatic logic [IDX_W-1:0] any_loaded();
        logic [IDX_W-1:0] v;
        int k;
        v = IDX_W'($urandom_range(0, NV - 1));
        for (k = 0; k < NV && !loaded[v]; k++) v = v + 1'b1;
        return v;
    endfunction

    task automatic send_item(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                             input logic [IN_COORD_W-1:0] px, py, pz,
                             input logic [IDX_W-1:0] ca, cb, cc);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {cc, cb, ca, pz, py, px, idx};
        do @(posedge aclk); while (!s_tready);
        n_sent++;
        n_kind[kind]++;
        if (kind == REQ_LOAD) loaded[idx] = 1'b1;
    endtask

    // unused fields of each beat carry random bits
    task automatic load_vert(input logic [IDX_W-1:0] idx,
                             input logic [IN_COORD_W-1:0] px, py, pz);
        send_item(REQ_LOAD, idx, px, py, pz,
                  IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic add_tri(input logic [IDX_W-1:0] ca, cb, cc);
        send_item(REQ_TRI, IDX_W'($urandom), $urandom, $urandom, $urandom, ca, cb, cc);
    endtask

    task automatic query(input logic [IDX_W-1:0] idx);
        send_item(REQ_QUERY, idx, $urandom, $urandom, $urandom,
                  IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic clear_adj();
        send_item(REQ_CLEAR, IDX_W'($urandom), $urandom, $urandom, $urandom,
                  IDX_W'($urandom), IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (n_waiting != 0) @(posedge aclk);
    endtask

    initial begin : stimulus
        int base, size, len, r, k, ep, i;
        logic [IDX_W-1:0] hub;
        bit hold_done;
        hold_done = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty mesh, coordinate extremes, repeated corners, clear
        query(0);
        load_vert(0, Q_MAX, Q_MAX, Q_MAX);
        load_vert(1, Q_MIN, Q_MIN, Q_MIN);
        load_vert(2, '0, '0, '0);
        load_vert(3, 32'hFFFF_FFFF, 32'h0000_0001, Q_MIN);
        load_vert(63, Q_MIN, Q_MAX, 32'h0001_8000);
        add_tri(0, 1, 2);
        query(0);
        query(1);
        query(2);
        add_tri(63, 63, 63);
        query(63);
        add_tri(3, 3, 0);
        query(3);
        query(0);
        add_tri(2, 1, 0);
        query(0);
        clear_adj();
        query(0);
        add_tri(1, 63, 3);
        query(63);
        query(1);

        while (n_sent < ITEMS) begin
            ep = $urandom_range(0, 11);
            tx_idle_on = ($urandom_range(0, 3) != 0);
            if (ep == 0) begin
                // fan around one hub drives its degree up to the maximum
                hub = IDX_W'($urandom_range(0, NV - 1));
                clear_adj();
                for (i = 0; i < NV; i++)
                    load_vert(IDX_W'(i), rand_coord(), rand_coord(), rand_coord());
                for (k = 0; k < NV - 1; k += 2)
                    add_tri(hub, IDX_W'(hub + k + 1), IDX_W'(hub + k + 2));
                query(hub);
                for (i = 0; i < 4; i++) query(IDX_W'($urandom));
            end else if (ep == 1) begin
                // noise: any kind, mid-sequence clears; loads and queries hit any vertex, triangles only loaded ones
                for (i = 0; i < 20; i++) begin
                    case ($urandom_range(0, 3))
                        0: load_vert(IDX_W'($urandom), rand_coord(), rand_coord(),
                                     rand_coord());
                        1: add_tri(any_loaded(), any_loaded(), any_loaded());
                        2: query(IDX_W'($urandom));
                        default: clear_adj();
                    endcase
                end
            end else begin
                // small mesh patch: positions, then loads, triangles, queries in it; rarely a stray query or clear
                base = $urandom_range(0, NV - 1);
                size = $urandom_range(3, 12);
                len  = $urandom_range(15, 40);
                for (k = 0; k < size; k++) begin
                    if (!loaded[(base + k) % NV] || $urandom_range(0, 2) == 0)
                        load_vert(IDX_W'((base + k) % NV),
                                  rand_coord(), rand_coord(), rand_coord());
                end
                for (i = 0; i < len; i++) begin
                    r = $urandom_range(0, 99);
                    if (r < 15)
                        load_vert(IDX_W'((base + $urandom_range(0, size - 1)) % NV),
                                  rand_coord(), rand_coord(), rand_coord());
                    else if (r < 55)
                        add_tri(IDX_W'((base + $urandom_range(0, size - 1)) % NV),
                                IDX_W'((base + $urandom_range(0, size - 1)) % NV),
                                IDX_W'((base + $urandom_range(0, size - 1)) % NV));
                    else if (r < 96)
                        query(IDX_W'((base + $urandom_range(0, size - 1)) % NV));
                    else if (r < 98)
                        query(IDX_W'($urandom));
                    else
                        clear_adj();
                end
            end
            if ($urandom_range(0, 3) == 0) clear_adj();
            if ($urandom_range(0, 4) == 0) drain_results();
            if (!hold_done && n_sent > ITEMS / 2) begin
                // receiver stalls for a long stretch while queries pile up behind it
                rx_hold_req = 1'b1;
                tx_idle_on  = 1'b0;
                for (i = 0; i < 8; i++) query(any_loaded());
                drain_results();
                hold_done = 1'b1;
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        $display("covered %0d loads, %0d triangles, %0d clears and %0d queries",
                 n_kind[REQ_LOAD], n_kind[REQ_TRI], n_kind[REQ_CLEAR], n_kind[REQ_QUERY]);
        $display("%0d result beats checked, %0d mismatches", n_results, n_fail);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
design/mlap_pkg.sv
design/mlap_adj.sv
design/mlap_div.sv
design/mesh_laplacian_delta_coords.sv
bench/mlap_checker.sv
bench/tb_top.sv
